[sv/swd_host_transaction_engine_macros.svh]
// Assertion helpers shared by the checking code of the SWD host engine.
// Both sample on the rising edge of clk_i and stay quiet while rst_ni is low.
`ifndef SWD_HOST_TRANSACTION_ENGINE_MACROS_SVH
`define SWD_HOST_TRANSACTION_ENGINE_MACROS_SVH

// A property that must hold at every clock edge.
`define SWD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define SWD_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

[sv/swd_pkg.sv]
package swd_pkg;

  // Length of each line reset, in SWCLK cycles.
  localparam int LINE_RESET_CYCLES = 50;

  localparam logic [31:0] TSEL_RESET = 32'h0100_2927;

  // Dormant-to-SWD selection alert, sent LSB first starting with byte 0x92.
  localparam logic [127:0] SELECTION_ALERT = 128'h19bc0ea2_e3ddafe9_86852d95_6209f392;
  localparam logic [7:0]   ACTIVATION_CODE = 8'h1A;
  localparam logic [15:0]  SWITCH_SEQ = 16'hE79E;
  localparam logic [2:0]   ACK_OK = 3'b001;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TSEL  = 2'd2;
  localparam logic [1:0] OP_ENTER = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_PARITY    = 2'd1;
  localparam logic [1:0] STATUS_ACK_FAULT = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [1:0]  op;
    logic        ap_not_dp;
    logic [1:0]  reg_addr;
    logic [31:0] write_value;
    logic        line_in;
  } in_item_t;

  typedef struct packed {
    logic        line_out;
    logic        drive_enable;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
    logic [2:0]  ack_code;
    logic [31:0] read_value;
  } out_item_t;

endpackage

[sv/swd_stream_if.sv]
interface swd_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/swd_host_transaction_engine.sv]
// SWD host transaction engine: every accepted beat is one start command or one SWCLK cycle.
// The result of a beat is registered in the output buffer when the beat is accepted.
// One beat per clock while the skid entry is empty; next phase and count are combinational.
// A two-entry output buffer keeps the input open while one result waits to be taken.
// Reset idles the sequencer, clears its state registers, loads TARGETSEL with 0x01002927
// and empties the output buffer.
module swd_host_transaction_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_wdata_i,
  swd_stream_if.sink           in_i,
  swd_stream_if.source         out_o
);

  localparam logic [4:0] PH_IDLE  = 5'd0;
  localparam logic [4:0] PH_PRE   = 5'd1;
  localparam logic [4:0] PH_ALERT = 5'd2;
  localparam logic [4:0] PH_BREAK = 5'd3;
  localparam logic [4:0] PH_ACT   = 5'd4;
  localparam logic [4:0] PH_LR1   = 5'd5;
  localparam logic [4:0] PH_SEQ   = 5'd6;
  localparam logic [4:0] PH_LR2   = 5'd7;
  localparam logic [4:0] PH_IDLE2 = 5'd8;
  localparam logic [4:0] PH_REQ   = 5'd9;
  localparam logic [4:0] PH_TRN1  = 5'd10;
  localparam logic [4:0] PH_ACK   = 5'd11;
  localparam logic [4:0] PH_TRN2  = 5'd12;
  localparam logic [4:0] PH_WDATA = 5'd13;
  localparam logic [4:0] PH_WPAR  = 5'd14;
  localparam logic [4:0] PH_RDATA = 5'd15;
  localparam logic [4:0] PH_RPAR  = 5'd16;
  localparam logic [4:0] PH_RTRN  = 5'd17;
  localparam logic [4:0] PH_TAIL  = 5'd18;

  // Index of the final cycle of each phase.
  function automatic logic [6:0] seg_last(input logic [4:0] ph);
    logic [6:0] r;
    case (ph)
      PH_PRE, PH_ACT, PH_REQ: r = 7'd7;
      PH_ALERT:               r = 7'd127;
      PH_BREAK:               r = 7'd3;
      PH_LR1, PH_LR2:         r = 7'(swd_pkg::LINE_RESET_CYCLES - 1);
      PH_SEQ:                 r = 7'd15;
      PH_IDLE2, PH_TAIL:      r = 7'd1;
      PH_ACK:                 r = 7'd2;
      PH_WDATA, PH_RDATA:     r = 7'd31;
      default:                r = 7'd0;
    endcase
    return r;
  endfunction

  logic [31:0] tsel_q;
  logic [4:0]  phase_q, phase_d;
  logic [6:0]  bit_cnt_q, bit_cnt_d;
  logic [31:0] shift_q, shift_d;
  logic [2:0]  ack_q, ack_d;
  logic        par_q, par_d;
  logic [1:0]  op_q, op_d;
  logic        ap_q, ap_d;
  logic [1:0]  ra_q, ra_d;
  logic [31:0] wlatch_q, wlatch_d;

  logic                out_v_q, skid_v_q;
  swd_pkg::out_item_t  out_q, skid_q;
  swd_pkg::in_item_t   item;
  swd_pkg::out_item_t  res;
  logic                in_acc, out_acc;

  logic [7:0] req_byte;
  logic       rq_ap, rq_rnw, rq_a2, rq_a3;
  logic [4:0] next_ph;
  logic       finish;

  assign item    = in_i.data;
  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_v_q && out_o.ready;

  assign in_i.ready  = !skid_v_q;
  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  // Request header: start, APnDP, RnW, A[2:3], parity, stop, park.
  always_comb begin
    if (op_q inside {swd_pkg::OP_TSEL, swd_pkg::OP_ENTER}) begin
      rq_ap  = 1'b0;
      rq_rnw = 1'b0;
      rq_a2  = 1'b1;
      rq_a3  = 1'b1;
    end else begin
      rq_ap  = ap_q;
      rq_rnw = (op_q == swd_pkg::OP_READ);
      rq_a2  = ra_q[0];
      rq_a3  = ra_q[1];
    end
    req_byte = {1'b1, 1'b0, rq_ap ^ rq_rnw ^ rq_a2 ^ rq_a3, rq_a3, rq_a2, rq_rnw, rq_ap, 1'b1};
  end

  always_comb begin
    phase_d   = phase_q;
    bit_cnt_d = bit_cnt_q;
    shift_d   = shift_q;
    ack_d     = ack_q;
    par_d     = par_q;
    op_d      = op_q;
    ap_d      = ap_q;
    ra_d      = ra_q;
    wlatch_d  = wlatch_q;
    res       = '0;
    res.drive_enable = 1'b1;
    next_ph   = PH_IDLE;
    finish    = 1'b0;

    if (item.kind == swd_pkg::KIND_START) begin
      // A start while a transaction runs is dropped.
      if (phase_q == PH_IDLE) begin
        op_d      = item.op;
        ap_d      = item.ap_not_dp;
        ra_d      = item.reg_addr;
        if (item.op == swd_pkg::OP_WRITE) begin
          wlatch_d = item.write_value;
        end else if (item.op inside {swd_pkg::OP_TSEL, swd_pkg::OP_ENTER}) begin
          wlatch_d = tsel_q;
        end else begin
          wlatch_d = '0;
        end
        phase_d   = (item.op == swd_pkg::OP_ENTER) ? PH_PRE : PH_REQ;
        bit_cnt_d = '0;
        shift_d   = '0;
        ack_d     = '0;
        par_d     = 1'b0;
      end
      res.busy_res = 1'b1;
    end else if (phase_q != PH_IDLE) begin
      case (phase_q)
        PH_PRE, PH_LR1, PH_LR2: res.line_out = 1'b1;
        PH_ALERT: res.line_out = swd_pkg::SELECTION_ALERT[bit_cnt_q];
        PH_BREAK, PH_IDLE2, PH_TAIL: res.line_out = 1'b0;
        PH_ACT:   res.line_out = swd_pkg::ACTIVATION_CODE[bit_cnt_q[2:0]];
        PH_SEQ:   res.line_out = swd_pkg::SWITCH_SEQ[bit_cnt_q[3:0]];
        PH_REQ:   res.line_out = req_byte[bit_cnt_q[2:0]];
        PH_ACK: begin
          res.drive_enable = 1'b0;
          ack_d = ack_q | (3'(item.line_in) << bit_cnt_q[1:0]);
        end
        PH_WDATA: res.line_out = wlatch_q[bit_cnt_q[4:0]];
        PH_WPAR:  res.line_out = ^wlatch_q;
        PH_RDATA: begin
          res.drive_enable = 1'b0;
          shift_d = shift_q | (32'(item.line_in) << bit_cnt_q[4:0]);
          par_d   = par_q ^ item.line_in;
        end
        PH_RPAR: begin
          res.drive_enable = 1'b0;
          par_d = par_q ^ item.line_in;
        end
        default: res.drive_enable = 1'b0;
      endcase

      if (bit_cnt_q == seg_last(phase_q)) begin
        bit_cnt_d = '0;
        case (phase_q)
          PH_PRE:   next_ph = PH_ALERT;
          PH_ALERT: next_ph = PH_BREAK;
          PH_BREAK: next_ph = PH_ACT;
          PH_ACT:   next_ph = PH_LR1;
          PH_LR1:   next_ph = PH_SEQ;
          PH_SEQ:   next_ph = PH_LR2;
          PH_LR2:   next_ph = PH_IDLE2;
          PH_IDLE2: next_ph = PH_REQ;
          PH_REQ:   next_ph = PH_TRN1;
          PH_TRN1:  next_ph = PH_ACK;
          PH_ACK: begin
            if (op_q == swd_pkg::OP_READ) begin
              next_ph = (ack_d == swd_pkg::ACK_OK) ? PH_RDATA : PH_RTRN;
            end else begin
              next_ph = PH_TRN2;
            end
          end
          PH_TRN2: begin
            // A write refused by the target ends on its turnaround cycle.
            if (op_q == swd_pkg::OP_WRITE && ack_q != swd_pkg::ACK_OK) begin
              finish = 1'b1;
            end else begin
              next_ph = PH_WDATA;
            end
          end
          PH_WDATA: next_ph = PH_WPAR;
          PH_WPAR: begin
            if (op_q == swd_pkg::OP_ENTER) begin
              next_ph = PH_TAIL;
            end else begin
              finish = 1'b1;
            end
          end
          PH_RDATA: next_ph = PH_RPAR;
          PH_RPAR:  next_ph = PH_RTRN;
          default:  finish = 1'b1;
        endcase
        phase_d = finish ? PH_IDLE : next_ph;
      end else begin
        bit_cnt_d = bit_cnt_q + 7'd1;
      end

      if (finish) begin
        res.done_res = 1'b1;
        res.ack_code = ack_d;
        if (op_q == swd_pkg::OP_READ) begin
          if (ack_d != swd_pkg::ACK_OK) begin
            res.status = swd_pkg::STATUS_ACK_FAULT;
          end else if (par_d) begin
            res.status = swd_pkg::STATUS_PARITY;
          end else begin
            res.status = swd_pkg::STATUS_OK;
          end
          res.read_value = (res.status == swd_pkg::STATUS_OK) ? shift_d : '1;
        end else if (op_q == swd_pkg::OP_WRITE) begin
          res.status = (ack_d != swd_pkg::ACK_OK) ? swd_pkg::STATUS_ACK_FAULT
                                                  : swd_pkg::STATUS_OK;
        end
      end
      res.busy_res = (phase_d != PH_IDLE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tsel_q    <= swd_pkg::TSEL_RESET;
      phase_q   <= PH_IDLE;
      bit_cnt_q <= '0;
      shift_q   <= '0;
      ack_q     <= '0;
      par_q     <= 1'b0;
      op_q      <= '0;
      ap_q      <= 1'b0;
      ra_q      <= '0;
      wlatch_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        tsel_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        phase_q   <= phase_d;
        bit_cnt_q <= bit_cnt_d;
        shift_q   <= shift_d;
        ack_q     <= ack_d;
        par_q     <= par_d;
        op_q      <= op_d;
        ap_q      <= ap_d;
        ra_q      <= ra_d;
        wlatch_q  <= wlatch_d;
      end
    end
  end

  // Output buffer: the main register feeds the port, the skid entry catches a
  // beat that arrives while the main register is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (in_acc) begin
        if (out_v_q && !out_o.ready) begin
          skid_v_q <= 1'b1;
        end else begin
          out_v_q <= 1'b1;
        end
      end else if (out_acc) begin
        if (skid_v_q) begin
          skid_v_q <= 1'b0;
        end else begin
          out_v_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (out_v_q && !out_o.ready) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end else if (out_acc && skid_v_q) begin
      out_q <= skid_q;
    end
  end

  `include "swd_host_transaction_engine_macros.svh"

  `SWD_ASSERT(a_skid_needs_out, !skid_v_q || out_v_q, "skid entry valid while output empty")
  `SWD_ASSERT(a_idle_count_zero, phase_q != PH_IDLE || bit_cnt_q == 7'd0, "bit count not zero in idle")
  `SWD_ASSERT_NEXT(a_stall_fills_skid, in_acc && out_v_q && !out_o.ready, skid_v_q, "stalled beat not caught")
  `SWD_ASSERT(a_count_in_segment, bit_cnt_q <= seg_last(phase_q), "bit count past segment end")

endmodule
